/* hw/rtl/hsv_pkg.sv */
// Shared types and constants for the RGB to HSV pixel converter.
package hsv_pkg;

    // Field widths
    localparam int CH_W    = 8;   // one colour channel
    localparam int HUE_W   = 9;   // hue in degrees, 0..359
    localparam int PCT_W   = 7;   // saturation and value in percent, 0..100
    localparam int NUM_W   = 15;  // dividend and partial remainder
    localparam int Q_W     = 7;   // quotient bits, one per divider stage
    localparam int DIV_STEPS = Q_W;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    // Arithmetic constants
    localparam int HUE_SCALE  = 60;
    localparam int PCT_SCALE  = 100;
    localparam int HUE_GREEN  = 120;
    localparam int HUE_BLUE   = 240;
    localparam int HUE_CIRCLE = 360;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } hue_sect_t;

    // Payload carried down the pipeline: two divider lanes plus sideband
    typedef struct packed {
        logic [NUM_W-1:0] hue_rem;
        logic [CH_W-1:0]  hue_div;
        logic [Q_W-1:0]   hue_q;
        logic [NUM_W-1:0] sat_rem;
        logic [CH_W-1:0]  sat_div;
        logic [Q_W-1:0]   sat_q;
        logic             grey;
        logic             black;
        logic             hue_neg;
        hue_sect_t        sect;
        logic [PCT_W-1:0] val;
    } stage_t;

endpackage

/* hw/rtl/rgb_to_hsv_pixel.sv */
// Top level of the RGB to HSV pixel converter: pipeline registers and flow control.
//
// Usage:
//   s_axis carries one RGB pixel of 8-bit channels per transfer (red, green, blue from the
//   lowest byte up); m_axis returns hue in degrees, saturation and value in
//   percent for each pixel, in order, one result per pixel.
// Pipeline: an accepted pixel passes one front-end register, seven divider
//   stages (one quotient bit each, the hue and saturation divisions side by
//   side) and one result register; the seven-stage divider sets the depth.
// Throughput: one pixel per cycle while m_axis_tready is high.
// Stall: each stage holds its item while the next stage is full and held, so
//   empty stages still fill while m_axis_tready is low; s_axis_tready falls
//   only once all nine stages hold an item. Nothing is lost or repeated.
// Reset: rst_n clears all stage valid bits; the block keeps no other state and
//   is ready for a pixel as soon as reset is released.
module rgb_to_hsv_pixel
    import hsv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [8:0] hue_deg, [15:9] sat_pct, [22:16] val_pct, [23] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    localparam int NSTAGE = DIV_STEPS + 2;
    localparam int LAST   = NSTAGE - 1;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE:0]   en;
    stage_t            st_reg [0:DIV_STEPS];
    stage_t            st_next [0:DIV_STEPS];
    logic [HUE_W-1:0]  hue_reg;
    logic [PCT_W-1:0]  sat_reg;
    logic [PCT_W-1:0]  val_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [PCT_W-1:0]  sat_next;
    logic [PCT_W-1:0]  val_next;

    // Stage advances when empty or when the stage after it advances
    assign en[NSTAGE] = m_axis_tready;
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign v_next = {v_reg[NSTAGE-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Front end
    hsv_front u_front (
        .red_in   (s_axis_tdata[CH_W-1:0]),
        .green_in (s_axis_tdata[2*CH_W-1:CH_W]),
        .blue_in  (s_axis_tdata[3*CH_W-1:2*CH_W]),
        .stage    (st_next[0])
    );

    // Divider stages
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        hsv_div_step u_step (
            .stage_in  (st_reg[i-1]),
            .stage_out (st_next[i])
        );
    end

    // Load payload only when a valid item moves in
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_STEPS; i++)
        begin
            if (en[i] && v_next[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Back end and result register
    hsv_back u_back (
        .stage   (st_reg[DIV_STEPS]),
        .hue_deg (hue_next),
        .sat_pct (sat_next),
        .val_pct (val_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[LAST] && v_next[LAST])
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[LAST];
    assign m_axis_tdata  = TDATA_OUT_W'({val_reg, sat_reg, hue_reg});

    // Input is refused only when every stage holds an item
    a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v_reg == '1))
        else $error("input stalled with an empty pipeline stage");

    // Hue stays inside the circle
    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (hue_reg < HUE_W'(HUE_CIRCLE)))
        else $error("hue out of range");

    // Percentages never exceed one hundred
    a_pct_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (sat_reg <= PCT_W'(PCT_SCALE) && val_reg <= PCT_W'(PCT_SCALE)))
        else $error("percentage out of range");

    // An accepted pixel reaches the first stage
    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted pixel lost at the front stage");

endmodule

/* hw/rtl/hsv_front.sv */
// Front end: max/min search, signed difference, dividends and value percentage.
module hsv_front
    import hsv_pkg::*;
(
    input  logic [CH_W-1:0] red_in,
    input  logic [CH_W-1:0] green_in,
    input  logic [CH_W-1:0] blue_in,
    output stage_t          stage
);

    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  d;
    logic [CH_W-1:0]  pos_a;
    logic [CH_W-1:0]  neg_a;
    logic [CH_W-1:0]  mag;
    logic             neg;
    hue_sect_t        sect;
    logic [NUM_W-1:0] val_prod;
    logic [NUM_W-1:0] val_inc;
    logic [NUM_W-1:0] val_sum;

    // Pick the maximum channel, red first then green
    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in)
        begin
            sect  = SECT_RED;
            mx    = red_in;
            pos_a = green_in;
            neg_a = blue_in;
        end
        else if (green_in >= blue_in)
        begin
            sect  = SECT_GREEN;
            mx    = green_in;
            pos_a = blue_in;
            neg_a = red_in;
        end
        else
        begin
            sect  = SECT_BLUE;
            mx    = blue_in;
            pos_a = red_in;
            neg_a = green_in;
        end
    end

    // Minimum and spread
    always_comb
    begin
        mn = red_in;
        if (green_in < mn)
        begin
            mn = green_in;
        end
        if (blue_in < mn)
        begin
            mn = blue_in;
        end
    end

    assign d = mx - mn;

    // Sign and magnitude of the hue difference
    assign neg = (pos_a < neg_a);
    assign mag = neg ? (neg_a - pos_a) : (pos_a - neg_a);

    // Value: floor(100*mx/255) through a reciprocal with correction
    assign val_prod = NUM_W'(mx) * NUM_W'(PCT_SCALE);
    assign val_inc  = val_prod + NUM_W'(1);
    assign val_sum  = val_inc + (val_inc >> CH_W);

    // Assemble the payload for the divider
    always_comb
    begin
        stage.hue_rem = NUM_W'(mag) * NUM_W'(HUE_SCALE);
        stage.hue_div = d;
        stage.hue_q   = '0;
        stage.sat_rem = NUM_W'(d) * NUM_W'(PCT_SCALE);
        stage.sat_div = mx;
        stage.sat_q   = '0;
        stage.grey    = (d == '0);
        stage.black   = (mx == '0);
        stage.hue_neg = neg;
        stage.sect    = sect;
        stage.val     = val_sum[CH_W +: PCT_W];
    end

endmodule

/* hw/rtl/hsv_div_step.sv */
// One restoring division step applied to both divider lanes.
module hsv_div_step
    import hsv_pkg::*;
(
    input  stage_t stage_in,
    output stage_t stage_out
);

    logic [NUM_W-1:0] hue_cmp;
    logic [NUM_W-1:0] sat_cmp;
    logic             hue_ge;
    logic             sat_ge;
    logic [NUM_W-1:0] hue_left;
    logic [NUM_W-1:0] sat_left;

    // Divisor aligned to the top quotient bit
    assign hue_cmp = NUM_W'({stage_in.hue_div, (Q_W-1)'(0)});
    assign sat_cmp = NUM_W'({stage_in.sat_div, (Q_W-1)'(0)});

    assign hue_ge = (stage_in.hue_rem >= hue_cmp);
    assign sat_ge = (stage_in.sat_rem >= sat_cmp);

    assign hue_left = hue_ge ? (stage_in.hue_rem - hue_cmp) : stage_in.hue_rem;
    assign sat_left = sat_ge ? (stage_in.sat_rem - sat_cmp) : stage_in.sat_rem;

    // Shift remainder up, append the quotient bit
    always_comb
    begin
        stage_out         = stage_in;
        stage_out.hue_rem = hue_left << 1;
        stage_out.hue_q   = {stage_in.hue_q[Q_W-2:0], hue_ge};
        stage_out.sat_rem = sat_left << 1;
        stage_out.sat_q   = {stage_in.sat_q[Q_W-2:0], sat_ge};
    end

endmodule

/* hw/rtl/hsv_back.sv */
// Back end: hue from sector, sign and quotient; saturation special cases.
module hsv_back
    import hsv_pkg::*;
(
    input  stage_t           stage,
    output logic [HUE_W-1:0] hue_deg,
    output logic [PCT_W-1:0] sat_pct,
    output logic [PCT_W-1:0] val_pct
);

    logic [HUE_W-1:0] q;
    logic [HUE_W-1:0] q_ceil;
    logic [HUE_W-1:0] hue_calc;

    assign q      = HUE_W'(stage.hue_q);
    assign q_ceil = q + HUE_W'(stage.hue_rem != '0);

    // Red truncates toward zero; green and blue floor
    always_comb
    begin
        unique case (stage.sect)
            SECT_RED:
            begin
                if (!stage.hue_neg)
                begin
                    hue_calc = q;
                end
                else if (q == '0)
                begin
                    hue_calc = '0;
                end
                else
                begin
                    hue_calc = HUE_W'(HUE_CIRCLE) - q;
                end
            end
            SECT_GREEN:
            begin
                hue_calc = stage.hue_neg ? (HUE_W'(HUE_GREEN) - q_ceil)
                                         : (HUE_W'(HUE_GREEN) + q);
            end
            SECT_BLUE:
            begin
                hue_calc = stage.hue_neg ? (HUE_W'(HUE_BLUE) - q_ceil)
                                         : (HUE_W'(HUE_BLUE) + q);
            end
            default:
            begin
                hue_calc = '0;
            end
        endcase
    end

    // Grey has no hue, black has no saturation
    assign hue_deg = stage.grey ? '0 : hue_calc;
    assign sat_pct = stage.black ? '0 : stage.sat_q;
    assign val_pct = stage.val;

endmodule
